>>> rtl/locd_pkg.sv
// Shared types, constants and codes for the lock-order cycle detector.
package locd_pkg;

  localparam int MaxLocks   = 16;
  localparam int Threads    = 8;
  localparam int StackDepth = 16;
  localparam int KeyBits    = 32;
  localparam int IdW        = $clog2(MaxLocks);
  localparam int CntW       = $clog2(MaxLocks + 1);
  localparam int ThW        = (Threads > 1) ? $clog2(Threads) : 1;
  localparam int HtW        = $clog2(StackDepth + 1);
  localparam int SpW        = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int OutLimit   = 16;
  localparam int OutCntW    = $clog2(OutLimit + 1);

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StMultiple = 3'd1;
  localparam logic [2:0] StInvalid  = 3'd2;
  localparam logic [2:0] StDeadlock = 3'd3;
  localparam logic [2:0] StFull     = 3'd4;
  localparam logic [2:0] StOverflow = 3'd5;
  localparam logic [2:0] StHalted   = 3'd6;

  localparam logic ActAcquire = 1'b0;
  localparam logic ActRelease = 1'b1;

  typedef struct packed {
    logic        action;
    logic [2:0]  thread_id;
    logic [31:0] lock_key;
  } locd_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] lock_id;
    logic [3:0] edge_from;
    logic [3:0] edge_to;
    logic       last;
  } locd_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;         // register the accepted item
    logic look_start;   // clear the key search
    logic look_step;    // compare one table entry
    logic alloc;        // assign a new id
    logic pop;
    logic push;
    logic add_edge;
    logic dfs_init;     // start a search
    logic dfs_step;     // one search step
    logic walk_start;
    logic walk_step;
    logic halt;
  } locd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_release;
    logic look_done;
    logic known;
    logic table_full;
    logic stack_empty;
    logic stack_full;
    logic top_match;
    logic edge_needed;
    logic dfs_done;
    logic dfs_cycle;
    logic walk_end;
    logic halted;
  } locd_sts_t;

endpackage

>>> rtl/locd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module locd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/locd_datapath.sv
// Datapath: key table, held-lock stacks, order graph and the cycle search.
module locd_datapath (
  input  logic                clk,
  input  logic                rst,
  input  locd_pkg::locd_in_t  item,
  input  locd_pkg::locd_cmd_t cmd,
  output locd_pkg::locd_sts_t sts,
  output logic [3:0]          lock_id,
  output logic [3:0]          edge_from,
  output logic [3:0]          edge_to
);
  import locd_pkg::*;

  locd_in_t cur;
  logic [ThW-1:0] thr;
  logic [CntW-1:0] lock_count;
  logic [IdW-1:0] id;
  logic known;
  logic [CntW-1:0] look_idx;
  logic [MaxLocks-1:0] order_edges [MaxLocks];
  logic [HtW-1:0] heights [Threads];
  logic halted;

  // Key table: one entry compared per cycle through the registered read.
  logic [KeyBits-1:0] key_rd;
  logic look_pending;

  locd_ram #(.Width(KeyBits), .Depth(MaxLocks)) u_keys (
    .clk  (clk),
    .we   (cmd.alloc),
    .waddr(lock_count[IdW-1:0]),
    .wdata(cur.lock_key[KeyBits-1:0]),
    .raddr(look_idx[IdW-1:0]),
    .rdata(key_rd)
  );

  // Held-lock stacks, addressed by thread and level.
  localparam int StkAw = ThW + SpW;
  logic [StkAw-1:0] stk_waddr, stk_raddr;
  logic [IdW-1:0] top_rd;
  logic [HtW-1:0] ht;

  assign ht = heights[thr];
  always_comb begin
    logic [HtW-1:0] tm;
    tm = ht - HtW'(1);
    stk_waddr = {thr, ht[SpW-1:0]};
    stk_raddr = {thr, tm[SpW-1:0]};
  end

  locd_ram #(.Width(IdW), .Depth(Threads * StackDepth)) u_stacks (
    .clk  (clk),
    .we   (cmd.push),
    .waddr(stk_waddr),
    .wdata(id),
    .raddr(stk_raddr),
    .rdata(top_rd)
  );

  assign thr = ThW'(cur.thread_id % Threads);

  // Search scratch.
  logic [MaxLocks-1:0] seen, done;
  logic [CntW-1:0] vis [MaxLocks];
  logic [IdW-1:0] parent [MaxLocks];
  logic [IdW-1:0] snode [MaxLocks];
  logic [CntW-1:0] snext [MaxLocks];
  logic [CntW-1:0] depth, vcnt, root;
  logic dfs_done, dfs_cycle;
  logic [IdW-1:0] cyc_h, cyc_t, walk_now;
  logic walk_end;
  logic [IdW-1:0] out_from, out_to;

  // One search step: find the next successor at or after the saved index.
  logic [IdW-1:0] h;
  logic [MaxLocks-1:0] cand;
  logic found;
  logic [IdW-1:0] j;
  always_comb begin
    h = snode[depth[IdW-1:0] - IdW'(1)];
    cand = '0;
    found = 1'b0;
    j = '0;
    for (int k = 0; k < MaxLocks; k++) begin
      cand[k] = order_edges[h][k] && (CntW'(k) >= snext[depth[IdW-1:0] - IdW'(1)])
                && (CntW'(k) < lock_count);
    end
    for (int k = MaxLocks - 1; k >= 0; k--) begin
      if (cand[k]) begin
        found = 1'b1;
        j = IdW'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_count <= '0;
      halted <= 1'b0;
      for (int t = 0; t < Threads; t++) heights[t] <= '0;
      for (int r = 0; r < MaxLocks; r++) order_edges[r] <= '0;
      look_pending <= 1'b0;
    end else begin
      if (cmd.take) cur <= item;
      if (cmd.look_start) begin
        look_idx <= '0;
        known <= 1'b0;
        id <= '0;
        look_pending <= 1'b0;
      end
      if (cmd.look_step) begin
        // Compare the entry read last cycle, then advance.
        if (look_pending && !known && key_rd == cur.lock_key[KeyBits-1:0]) begin
          known <= 1'b1;
          id <= IdW'(look_idx - CntW'(1));
        end
        if (look_idx < lock_count) look_idx <= look_idx + CntW'(1);
        look_pending <= (look_idx < lock_count);
      end
      if (cmd.alloc) begin
        id <= lock_count[IdW-1:0];
        order_edges[lock_count[IdW-1:0]] <= '0;
        lock_count <= lock_count + CntW'(1);
      end
      if (cmd.pop) heights[thr] <= ht - HtW'(1);
      if (cmd.push) heights[thr] <= ht + HtW'(1);
      if (cmd.add_edge) order_edges[top_rd][id] <= 1'b1;
      if (cmd.halt) halted <= 1'b1;
      if (cmd.dfs_init) begin
        seen <= '0;
        done <= '0;
        depth <= '0;
        vcnt <= '0;
        root <= '0;
        dfs_done <= 1'b0;
        dfs_cycle <= 1'b0;
      end
      if (cmd.dfs_step && !dfs_done) begin
        if (depth == '0) begin
          if (root >= lock_count) begin
            dfs_done <= 1'b1;
          end else if (seen[root[IdW-1:0]]) begin
            root <= root + CntW'(1);
          end else begin
            seen[root[IdW-1:0]] <= 1'b1;
            vis[root[IdW-1:0]] <= vcnt;
            vcnt <= vcnt + CntW'(1);
            snode[0] <= root[IdW-1:0];
            snext[0] <= '0;
            depth <= CntW'(1);
            root <= root + CntW'(1);
          end
        end else if (!found) begin
          done[h] <= 1'b1;
          depth <= depth - CntW'(1);
        end else begin
          snext[depth[IdW-1:0] - IdW'(1)] <= CntW'(j) + CntW'(1);
          if (!seen[j]) begin
            parent[j] <= h;
            seen[j] <= 1'b1;
            vis[j] <= vcnt;
            vcnt <= vcnt + CntW'(1);
            if (depth < CntW'(MaxLocks)) begin
              snode[depth[IdW-1:0]] <= j;
              snext[depth[IdW-1:0]] <= '0;
              depth <= depth + CntW'(1);
            end
          end else if (vis[h] >= vis[j] && !done[j]) begin
            cyc_h <= h;
            cyc_t <= j;
            dfs_cycle <= 1'b1;
            dfs_done <= 1'b1;
          end
        end
      end
      if (cmd.walk_start) begin
        out_from <= cyc_h;
        out_to <= cyc_t;
        walk_now <= cyc_h;
        walk_end <= 1'b0;
      end
      if (cmd.walk_step) begin
        out_from <= parent[walk_now];
        out_to <= walk_now;
        walk_now <= parent[walk_now];
        walk_end <= (parent[walk_now] == cyc_t);
      end
    end
  end

  assign sts.is_release  = (cur.action == ActRelease);
  assign sts.look_done   = !(look_idx < lock_count) && !look_pending;
  assign sts.known       = known;
  assign sts.table_full  = (lock_count >= CntW'(MaxLocks));
  assign sts.stack_empty = (ht == '0);
  assign sts.stack_full  = (ht >= HtW'(StackDepth));
  assign sts.top_match   = (top_rd == id);
  assign sts.edge_needed = (top_rd != id) && !order_edges[top_rd][id];
  assign sts.dfs_done    = dfs_done;
  assign sts.dfs_cycle   = dfs_cycle;
  assign sts.walk_end    = walk_end;
  assign sts.halted      = halted;

  assign lock_id   = 4'(id);
  assign edge_from = 4'(out_from);
  assign edge_to   = 4'(out_to);

endmodule

>>> rtl/locd_ctrl.sv
// Controller state machine: sequences one transaction through the datapath.
module locd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [2:0]           status,
  output logic                 last,
  output logic                 edges_on,
  output logic                 id_on,
  input  locd_pkg::locd_sts_t  sts,
  output locd_pkg::locd_cmd_t  cmd
);
  import locd_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_LOOK0 = 8'b00000010,
    S_LOOK  = 8'b00000100,
    S_DEC   = 8'b00001000,
    S_CHK   = 8'b00010000,
    S_DFS   = 8'b00100000,
    S_OUT   = 8'b01000000,
    S_WALK  = 8'b10000000
  } state_t;

  state_t state, state_next;
  logic [2:0] st_next;
  logic last_next, edges_next, id_next;
  logic [OutCntW-1:0] nout, nout_next;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd = '0;
    state_next = state;
    st_next = status;
    last_next = last;
    edges_next = edges_on;
    id_next = id_on;
    nout_next = nout;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          state_next = S_LOOK0;
        end
      end
      S_LOOK0: begin
        cmd.look_start = 1'b1;
        state_next = S_LOOK;
      end
      S_LOOK: begin
        if (sts.halted) begin
          st_next = StHalted; id_next = 1'b0; edges_next = 1'b0; last_next = 1'b1;
          state_next = S_OUT;
        end else if (sts.look_done) begin
          state_next = S_DEC;
        end else begin
          cmd.look_step = 1'b1;
        end
      end
      S_DEC: begin
        edges_next = 1'b0; last_next = 1'b1; id_next = 1'b1;
        if (sts.is_release) begin
          state_next = S_CHK;
        end else if (!sts.known && sts.table_full) begin
          cmd.halt = 1'b1; st_next = StFull; id_next = 1'b0;
          state_next = S_OUT;
        end else begin
          if (!sts.known) cmd.alloc = 1'b1;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        state_next = S_OUT;
        if (sts.is_release) begin
          if (sts.stack_empty) begin
            cmd.halt = 1'b1; st_next = StMultiple;
          end else if (!sts.known || !sts.top_match) begin
            cmd.halt = 1'b1; st_next = StInvalid;
          end else begin
            cmd.pop = 1'b1; st_next = StOk;
          end
        end else if (sts.stack_full) begin
          cmd.halt = 1'b1; st_next = StOverflow;
        end else if (!sts.stack_empty && sts.edge_needed) begin
          cmd.add_edge = 1'b1;
          cmd.dfs_init = 1'b1;
          state_next = S_DFS;
        end else begin
          cmd.push = 1'b1; st_next = StOk;
        end
      end
      S_DFS: begin
        if (sts.dfs_done) begin
          state_next = S_OUT;
          if (sts.dfs_cycle) begin
            // The closing edge goes out first and is never the final one.
            cmd.halt = 1'b1;
            cmd.walk_start = 1'b1;
            st_next = StDeadlock; edges_next = 1'b1; last_next = 1'b0;
            nout_next = OutCntW'(1);
          end else begin
            cmd.push = 1'b1; st_next = StOk;
          end
        end else begin
          cmd.dfs_step = 1'b1;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          if (last) begin
            state_next = S_IDLE;
          end else begin
            cmd.walk_step = 1'b1;
            state_next = S_WALK;
          end
        end
      end
      S_WALK: begin
        // The step has formed the next edge; it ends the report at the cycle's start
        // or when the result limit is reached.
        nout_next = nout + OutCntW'(1);
        last_next = sts.walk_end || (nout + OutCntW'(1) >= OutCntW'(OutLimit));
        state_next = S_OUT;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      status <= StOk; last <= 1'b0; edges_on <= 1'b0; id_on <= 1'b0;
      nout <= '0;
    end else begin
      state <= state_next;
      status <= st_next;
      last <= last_next;
      edges_on <= edges_next;
      id_on <= id_next;
      nout <= nout_next;
    end
  end

endmodule

>>> rtl/lock_order_cycle_detector.sv
// Top level of the lock-order cycle detector.
// One transaction is handled at a time. A lookup walks the key table one entry a cycle,
// then a release or a plain acquire completes through the decode and check states, and
// an acquire that adds an order edge runs a depth-first search of the order graph, one
// search step per cycle. A found cycle is reported as one result per cycle edge; each
// further edge is formed in a walk state between results, and the output waits while
// it is stalled. Any error halts the block until reset; later transactions each give a
// single halted result.
module lock_order_cycle_detector (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  locd_pkg::locd_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output locd_pkg::locd_out_t  out_data
);
  import locd_pkg::*;

  locd_cmd_t cmd;
  locd_sts_t sts;
  logic [3:0] lock_id, edge_from, edge_to;
  logic [2:0] status;
  logic last, edges_on, id_on;
  locd_out_t res;

  locd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_stall(out_stall), .out_valid(out_valid), .status(status), .last(last),
    .edges_on(edges_on), .id_on(id_on), .sts(sts), .cmd(cmd)
  );

  locd_datapath u_dp (
    .clk(clk), .rst(rst), .item(in_data), .cmd(cmd), .sts(sts),
    .lock_id(lock_id), .edge_from(edge_from), .edge_to(edge_to)
  );

  always_comb begin
    res.status    = status;
    res.lock_id   = id_on ? lock_id : 4'd0;
    res.edge_from = edges_on ? edge_from : 4'd0;
    res.edge_to   = edges_on ? edge_to : 4'd0;
    res.last      = last;
  end
  assign out_data = res;

endmodule
